// ===== hdl/vtxts_pkg.sv =====
`default_nettype none
package vtxts_pkg;

  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned UC_DEPTH    = FRAME_BYTES + 1;
  localparam int unsigned STEP_W      = $clog2(UC_DEPTH);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  SYNC_BYTE   = 8'h0F;
  localparam logic [7:0]  CMD_FREQ    = 8'h46;  // 'F'
  localparam logic [7:0]  CMD_POWER   = 8'h50;  // 'P'
  localparam logic [7:0]  CRC_POLY    = 8'hD5;
  localparam logic [7:0]  ZERO_BYTE   = 8'h00;

  localparam logic [15:0] FREQ_RESET  = 16'd5800;
  localparam logic [15:0] POWER_RESET = 16'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ  = 2'd0,
    CFG_POWER = 2'd1,
    CFG_LPD   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_INIT  = 4'b0001,
    PH_CHAN  = 4'b0010,
    PH_POWER = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    SEL_SYNC   = 3'd0,
    SEL_LETTER = 3'd1,
    SEL_PLO    = 3'd2,
    SEL_PHI    = 3'd3,
    SEL_ZERO   = 3'd4,
    SEL_CRC    = 3'd5
  } byte_sel_e;

  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_DISPATCH = 2'd1,
    J_HOME     = 2'd2
  } jump_e;

  typedef struct packed {
    logic      take_item;
    logic      emit;
    byte_sel_e sel;
    logic      last;
    jump_e     jump;
  } ucode_t;

  typedef struct packed {
    logic      load_cmd;
    logic      cmd_power;
    logic      emit;
    byte_sel_e sel;
    logic      last;
  } ctrl_t;

  // Microcode program: step 0 takes an item and dispatches, steps 1..16 emit the frame.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{take_item: 1'b0, emit: 1'b1, sel: SEL_ZERO, last: 1'b0, jump: J_NEXT};
    if (step == '0 || step > STEP_W'(FRAME_BYTES)) begin
      w = '{take_item: 1'b1, emit: 1'b0, sel: SEL_ZERO, last: 1'b0, jump: J_DISPATCH};
    end else if (step == STEP_W'(1)) begin
      w.sel = SEL_SYNC;
    end else if (step == STEP_W'(2)) begin
      w.sel = SEL_LETTER;
    end else if (step == STEP_W'(3)) begin
      w.sel = SEL_PLO;
    end else if (step == STEP_W'(4)) begin
      w.sel = SEL_PHI;
    end else if (step == STEP_W'(FRAME_BYTES - 1)) begin
      w.sel = SEL_CRC;
    end else if (step == STEP_W'(FRAME_BYTES)) begin
      w.last = 1'b1;
      w.jump = J_HOME;
    end
    return w;
  endfunction

  // One byte of CRC-8 DVB-S2, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vtxts_if.sv =====
`default_nettype none
interface vtxts_item_if;
  logic valid;
  logic ready;
  logic armed;
  modport source (output valid, output armed, input ready);
  modport sink   (input valid, input armed, output ready);
endinterface

interface vtxts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface vtxts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/vtxts_seq.sv =====
`default_nettype none
module vtxts_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          armed_i,
  output logic               in_ready_o,
  input  wire logic          emit_ok_i,
  output vtxts_pkg::ctrl_t   ctrl_o
);
  import vtxts_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  phase_e            phase_q, phase_d;
  logic              seen_q, seen_d;
  ucode_t            uc;
  logic              fire_in, advance, send, send_power;

  assign uc         = ucode(step_q);
  assign in_ready_o = uc.take_item;
  assign fire_in    = in_valid_i && uc.take_item;
  assign advance    = uc.emit && emit_ok_i;

  always_comb begin
    phase_d    = phase_q;
    seen_d     = seen_q;
    send       = 1'b0;
    send_power = 1'b0;
    if (fire_in) begin
      unique case (phase_q)
        PH_INIT: phase_d = PH_CHAN;
        PH_CHAN: begin
          phase_d = PH_POWER;
          send    = 1'b1;
        end
        PH_POWER: begin
          phase_d    = PH_IDLE;
          send       = 1'b1;
          send_power = 1'b1;
        end
        PH_IDLE: begin
          // A change of the armed flag schedules a power frame on the next item.
          if (armed_i != seen_q) begin
            seen_d  = ~seen_q;
            phase_d = PH_POWER;
          end
        end
        default: phase_d = PH_INIT;
      endcase
    end
  end

  always_comb begin
    step_d = step_q;
    unique case (uc.jump)
      J_DISPATCH: if (send) step_d = STEP_W'(1);
      J_NEXT:     if (advance) step_d = step_q + STEP_W'(1);
      J_HOME:     if (advance) step_d = '0;
      default:    step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      phase_q <= PH_INIT;
      seen_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
    end
  end

  assign ctrl_o = '{load_cmd: send, cmd_power: send_power, emit: uc.emit,
                    sel: uc.sel, last: uc.last};

endmodule
`default_nettype wire

// ===== hdl/vtxts_dp.sv =====
`default_nettype none
module vtxts_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vtxts_pkg::ctrl_t  ctrl_i,
  input  wire logic              armed_i,
  input  wire logic [15:0]       freq_i,
  input  wire logic [15:0]       power_i,
  input  wire logic              lpd_i,
  output logic                   emit_ok_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             frame_byte_o,
  output logic                   last_byte_o
);
  import vtxts_pkg::*;

  logic [7:0]  letter_q;
  logic [15:0] param_q;
  logic [7:0]  crc_q;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [7:0]  cur_byte;
  logic        load_out;

  always_comb begin
    case (ctrl_i.sel)
      SEL_SYNC:   cur_byte = SYNC_BYTE;
      SEL_LETTER: cur_byte = letter_q;
      SEL_PLO:    cur_byte = param_q[7:0];
      SEL_PHI:    cur_byte = param_q[15:8];
      SEL_CRC:    cur_byte = crc_q;
      default:    cur_byte = ZERO_BYTE;
    endcase
  end

  assign emit_ok_o = !valid_q || out_ready_i;
  assign load_out  = ctrl_i.emit && emit_ok_o;

  // The CRC runs over every byte sent; only the value held before the CRC byte is used.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      letter_q <= ctrl_i.cmd_power ? CMD_POWER : CMD_FREQ;
      if (!ctrl_i.cmd_power) begin
        param_q <= freq_i;
      end else begin
        param_q <= (lpd_i && !armed_i) ? 16'd0 : power_i;
      end
      crc_q <= ZERO_BYTE;
    end else if (load_out) begin
      crc_q <= crc8_byte(crc_q, cur_byte);
    end
    if (load_out) begin
      byte_q <= cur_byte;
      last_q <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_out) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule
`default_nettype wire

// ===== hdl/vtx_tramp_command_sequencer.sv =====
`default_nettype none
// Channel   Direction  Payload                    Handshake
// item_i    in         armed (1)                  valid/ready
// byte_o    out        frame_byte (8), last_byte  valid/ready
// cfg_i     in         index (2), data (16)       valid/ready, ready always high
//
// An item is taken at microcode step 0; an item that starts a frame then runs steps
// 1 to 16, one frame byte per cycle while the output register does not stall.
// The output register stalls the step counter while a byte waits to be taken.
// Reset clears the step counter, phase, armed flag and output valid and loads the
// configuration reset values; the frame registers are loaded before they are used.
module vtx_tramp_command_sequencer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vtxts_item_if.sink item_i,
  vtxts_byte_if.source byte_o,
  vtxts_cfg_if.sink  cfg_i
);
  import vtxts_pkg::*;

  logic [15:0] freq_q;
  logic [15:0] power_q;
  logic        lpd_q;
  ctrl_t       ctrl;
  logic        emit_ok;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FREQ_RESET;
      power_q <= POWER_RESET;
      lpd_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FREQ:  freq_q  <= cfg_i.data;
        CFG_POWER: power_q <= cfg_i.data;
        CFG_LPD:   lpd_q   <= cfg_i.data[0];
        default:   ;
      endcase
    end
  end

  vtxts_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .armed_i    (item_i.armed),
    .in_ready_o (item_i.ready),
    .emit_ok_i  (emit_ok),
    .ctrl_o     (ctrl)
  );

  vtxts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .armed_i      (item_i.armed),
    .freq_i       (freq_q),
    .power_i      (power_q),
    .lpd_i        (lpd_q),
    .emit_ok_o    (emit_ok),
    .out_valid_o  (byte_o.valid),
    .out_ready_i  (byte_o.ready),
    .frame_byte_o (byte_o.frame_byte),
    .last_byte_o  (byte_o.last_byte)
  );

endmodule
`default_nettype wire
